>>> sv/dfcr_pkg.sv
// Shared definitions for the damped feedback comb reverb.
// Holds constants, register map, configuration and control structs.
// No dependencies; every other file of the block uses this package.
package dfcr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DELAY_DEPTH_DEF = 131072;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Register field widths.
  localparam int unsigned DLY_W  = 17;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned WET_W  = 17;

  // Coefficient width: unsigned Q0.16 with room for the value one.
  localparam int unsigned COEF_W = 17;

  // Lowpass coefficients, 0.4 and 0.6 in Q0.16, summing to exactly one.
  localparam logic [COEF_W-1:0] COEF_OLD = 17'd26214;
  localparam logic [COEF_W-1:0] COEF_NEW = 17'd39322;
  localparam logic [COEF_W-1:0] Q_ONE    = 17'd65536;

  // APB register map.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_DELAY = 2'd0,
    REG_GAIN  = 2'd1,
    REG_WET   = 2'd2
  } reg_idx_e;

  // Reset values of the registers.
  localparam logic [DLY_W-1:0]  DELAY_RST = 17'd4851;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd55705;
  localparam logic [WET_W-1:0]  WET_RST   = 17'd26214;

  typedef struct packed {
    logic [DLY_W-1:0]  delay_length;
    logic [GAIN_W-1:0] feedback_gain;
    logic [WET_W-1:0]  wet_mix;
  } cfg_t;

  // Operand pair selected for the shared multiply-accumulate.
  typedef enum logic [2:0] {
    MAC_OLD = 3'd0,
    MAC_NEW = 3'd1,
    MAC_DRY = 3'd2,
    MAC_WET = 3'd3,
    MAC_FB  = 3'd4
  } mac_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_x;
    logic     mem_rd;
    logic     mac_en;
    logic     mac_clr;
    mac_sel_e mac_sel;
    logic     damp_upd;
    logic     out_load;
    logic     fb_write;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

>>> sv/dfcr_regs.sv
// APB configuration registers of the damped feedback comb reverb.
// Holds delay length, feedback gain and wet mix; depends on dfcr_pkg.
module dfcr_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dfcr_pkg::APB_AW-1:0]  paddr,
  input  logic [dfcr_pkg::APB_DW-1:0]  pwdata,
  output logic [dfcr_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output dfcr_pkg::cfg_t               cfg_o
);
  import dfcr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  // Register write decode; writes beyond the map are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_DELAY: cfg_d.delay_length  = pwdata[DLY_W-1:0];
        REG_GAIN:  cfg_d.feedback_gain = pwdata[GAIN_W-1:0];
        REG_WET:   cfg_d.wet_mix       = pwdata[WET_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_length  <= DELAY_RST;
      cfg_q.feedback_gain <= GAIN_RST;
      cfg_q.wet_mix       <= WET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_sel)
      REG_DELAY: prdata = APB_DW'(cfg_q.delay_length);
      REG_GAIN:  prdata = APB_DW'(cfg_q.feedback_gain);
      REG_WET:   prdata = APB_DW'(cfg_q.wet_mix);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/dfcr_ctrl.sv
// Sequencing state machine of the damped feedback comb reverb.
// Steps one sample through read, five multiply-accumulates and write-back.
// Depends on dfcr_pkg for the command and status structs.
module dfcr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dfcr_pkg::sts_t sts_i,
  output dfcr_pkg::cmd_t cmd_o
);
  import dfcr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ACC_NEW = 6'b000010,
    ST_DAMP    = 6'b000100,
    ST_ACC_WET = 6'b001000,
    ST_EMIT    = 6'b010000,
    ST_FEED    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // Take the sample, read the delay line and start the lowpass.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_x  = 1'b1;
          cmd_o.mem_rd  = 1'b1;
          cmd_o.mac_en  = 1'b1;
          cmd_o.mac_clr = 1'b1;
          cmd_o.mac_sel = MAC_OLD;
          state_d       = ST_ACC_NEW;
        end
      end
      ST_ACC_NEW: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_sel = MAC_NEW;
        state_d       = ST_DAMP;
      end
      ST_DAMP: begin
        // Lowpass result lands while the output mix begins.
        cmd_o.damp_upd = 1'b1;
        cmd_o.mac_en   = 1'b1;
        cmd_o.mac_clr  = 1'b1;
        cmd_o.mac_sel  = MAC_DRY;
        state_d        = ST_ACC_WET;
      end
      ST_ACC_WET: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_sel = MAC_WET;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold here until the output register can take the result.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.mac_en   = 1'b1;
          cmd_o.mac_clr  = 1'b1;
          cmd_o.mac_sel  = MAC_FB;
          state_d        = ST_FEED;
        end
      end
      ST_FEED: begin
        cmd_o.fb_write = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/dfcr_dp.sv
// Datapath of the damped feedback comb reverb: delay memory, write pointer,
// shared multiply-accumulate, lowpass state and output register.
// Depends on dfcr_pkg; driven by commands from dfcr_ctrl.
module dfcr_dp #(
  parameter int unsigned DELAY_DEPTH = dfcr_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = dfcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dfcr_pkg::cfg_t         cfg_i,
  input  dfcr_pkg::cmd_t         cmd_i,
  output dfcr_pkg::sts_t         sts_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] mix_out_o
);
  import dfcr_pkg::*;

  localparam int unsigned AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned LW    = ((AW > DLY_W) ? AW : DLY_W) + 1;
  localparam int unsigned PW    = SAMPLE_BITS + COEF_W + 1;
  localparam int unsigned ACC_W = PW + 1;
  localparam int unsigned QW    = ACC_W - 16;
  localparam logic [LW-1:0] DEPTH_L = LW'(DELAY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic signed [QW-1:0] SMAX_Q =
    $signed({{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [QW-1:0] SMIN_Q =
    $signed({{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});
  localparam logic signed [SAMPLE_BITS-1:0] SMAX =
    $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SAMPLE_BITS-1:0] SMIN =
    $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  // Round half up, drop 16 fraction bits and saturate to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] t;
    logic signed [QW-1:0]    q;
    t = v + $signed({{(ACC_W-16){1'b0}}, 16'h8000});
    q = t[ACC_W-1:16];
    if (q > SMAX_Q) begin
      rnd_sat = SMAX;
    end else if (q < SMIN_Q) begin
      rnd_sat = SMIN;
    end else begin
      rnd_sat = q[SAMPLE_BITS-1:0];
    end
  endfunction

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic [AW-1:0]                 wp_q, wp_d;
  logic                          wrapped_q, wrapped_d;
  logic                          rd_hit_q;
  logic [SAMPLE_BITS-1:0]        rdata_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] damp_q, damp_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic [SAMPLE_BITS-1:0]        out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic [LW-1:0]                 dly_ext, dly_eff, wp_ext, rd_ext;
  logic                          rd_hit;
  logic [AW-1:0]                 rd_addr;
  logic [COEF_W-1:0]             wet_eff, dry_eff;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic [COEF_W-1:0]             mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [SAMPLE_BITS-1:0] fb_rnd;
  logic signed [SAMPLE_BITS:0]   fb_sum;
  logic [SAMPLE_BITS-1:0]        fb_val;

  // Clamp the delay into one to depth minus one and form the read address.
  always_comb begin
    dly_ext = LW'(cfg_i.delay_length);
    if (dly_ext == '0) begin
      dly_eff = LW'(1);
    end else if (dly_ext >= DEPTH_L) begin
      dly_eff = DEPTH_L - LW'(1);
    end else begin
      dly_eff = dly_ext;
    end
    wp_ext = LW'(wp_q);
    rd_hit = (wp_ext >= dly_eff);
    rd_ext = rd_hit ? (wp_ext - dly_eff) : (wp_ext + DEPTH_L - dly_eff);
    rd_addr = rd_ext[AW-1:0];
  end

  // Delay memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fb_write) begin
      mem[wp_q] <= fb_val;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // An entry counts as written once the pointer has passed it or wrapped;
  // entries never written read as zero.
  assign delayed = rd_hit_q ? $signed(rdata_q) : '0;

  // Wet share above one acts as one.
  always_comb begin
    wet_eff = (cfg_i.wet_mix > Q_ONE) ? Q_ONE : cfg_i.wet_mix;
    dry_eff = Q_ONE - wet_eff;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    case (cmd_i.mac_sel)
      MAC_OLD: begin
        mul_a = damp_q;
        mul_b = COEF_OLD;
      end
      MAC_NEW: begin
        mul_a = delayed;
        mul_b = COEF_NEW;
      end
      MAC_DRY: begin
        mul_a = x_q;
        mul_b = dry_eff;
      end
      MAC_WET: begin
        mul_a = delayed;
        mul_b = wet_eff;
      end
      MAC_FB: begin
        mul_a = damp_q;
        mul_b = COEF_W'(cfg_i.feedback_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Multiply-accumulate into the accumulator register.
  always_comb begin
    prod  = mul_a * $signed({1'b0, mul_b});
    acc_d = acc_q;
    if (cmd_i.mac_en) begin
      if (cmd_i.mac_clr) begin
        acc_d = $signed({prod[PW-1], prod});
      end else begin
        acc_d = acc_q + $signed({prod[PW-1], prod});
      end
    end
  end

  // Feedback value: input plus rounded damped product, saturated.
  always_comb begin
    fb_rnd = rnd_sat(acc_q);
    fb_sum = {x_q[SAMPLE_BITS-1], x_q} + {fb_rnd[SAMPLE_BITS-1], fb_rnd};
    if (fb_sum[SAMPLE_BITS] != fb_sum[SAMPLE_BITS-1]) begin
      fb_val = fb_sum[SAMPLE_BITS] ? SMIN : SMAX;
    end else begin
      fb_val = fb_sum[SAMPLE_BITS-1:0];
    end
  end

  // Lowpass state, write pointer and output register next values.
  always_comb begin
    damp_d      = cmd_i.damp_upd ? rnd_sat(acc_q) : damp_q;
    wp_d        = wp_q;
    wrapped_d   = wrapped_q;
    if (cmd_i.fb_write) begin
      if (wp_q == WP_LAST) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + AW'(1);
      end
    end
    out_d       = cmd_i.out_load ? rnd_sat(acc_q) : out_q;
    out_valid_d = cmd_i.out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      damp_q      <= '0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      damp_q      <= damp_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.mem_rd) begin
        rd_hit_q <= rd_hit | wrapped_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
    if (cmd_i.load_x) begin
      x_q <= $signed(in_sample_i);
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign mix_out_o      = out_q;

endmodule

>>> sv/damped_feedback_comb_reverb.sv
// Top level of the damped feedback comb reverb.
// Instantiates dfcr_regs, dfcr_ctrl and dfcr_dp; depends on dfcr_pkg.
//
//   Port group   Handshake               Carries
//   input        in_valid_i/in_ready_o   in_sample_i
//   output       out_valid_o/out_ready_i mix_out_o
//   config       APB psel/penable        delay_length, feedback_gain, wet_mix
//
// After a sample's transfer the block passes the ACC_NEW, DAMP, ACC_WET, EMIT
// and FEED states before it is ready again, as one shared multiplier-accumulator
// forms five products in turn around one read and one write of the delay memory.
// The result is registered in the EMIT state; if the previous result has not
// been taken, the block waits there before loading the new one.
// Reset needs no clearing pass: a wrap flag marks delay entries never written,
// which read as zero.
module damped_feedback_comb_reverb #(
  parameter int unsigned DELAY_DEPTH = dfcr_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = dfcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       in_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SAMPLE_BITS-1:0]       mix_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dfcr_pkg::APB_AW-1:0]  paddr,
  input  logic [dfcr_pkg::APB_DW-1:0]  pwdata,
  output logic [dfcr_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import dfcr_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers.
  dfcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer.
  dfcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Delay line and arithmetic.
  dfcr_dp #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mix_out_o    (mix_out_o)
  );

endmodule

>>> sv/dfcr_checker.sv
// Port-level assertions for the damped feedback comb reverb.
// Bound to damped_feedback_comb_reverb; depends on dfcr_pkg.
module dfcr_checker #(
  parameter int unsigned SAMPLE_BITS = dfcr_pkg::SAMPLE_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [SAMPLE_BITS-1:0]       mix_out_o,
  input logic                         pready
);

  // A waiting result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mix_out_o))
    else $error("output result changed or dropped while stalled");

  // After an input transfer the block stays busy while the sample is processed.
  a_busy_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o
      ##1 !in_ready_o)
    else $error("input accepted again before the sample was processed");

  // A new result is loaded only while a sample is in flight.
  a_out_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result produced with no sample in progress");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind damped_feedback_comb_reverb dfcr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dfcr_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for damped_feedback_comb_reverb.
// Drives samples and APB register writes, predicts every output sample in a
// scoreboard class and compares each transfer. Depends on dfcr_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dfcr_pkg::*;

  localparam int unsigned SW          = SAMPLE_BITS_DEF;
  localparam int unsigned REG_STRIDE  = 4;
  localparam int          REG_SPARE   = 3;     // index past the register map
  localparam int          SETTLE      = 12;    // cycles for the last memory write
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 240;

  // Predicts the reverb output and keeps the samples still to be seen.
  class reverb_predictor;
    localparam int unsigned DEPTH = DELAY_DEPTH_DEF;
    localparam longint      S_MAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint      S_MIN = -S_MAX - 1;

    bit signed [SW-1:0] echo_line [DEPTH];
    bit [DLY_W-1:0]     head;
    bit signed [SW-1:0] lowpass;
    cfg_t               cfg;
    bit [SW-1:0]        pending_out [$];
    int                 fail_count;

    function new();
      head    = '0;
      lowpass = '0;
      cfg.delay_length  = DELAY_RST;
      cfg.feedback_gain = GAIN_RST;
      cfg.wet_mix       = WET_RST;
      fail_count = 0;
    endfunction

    function longint clip(longint v);
      if (v > S_MAX) return S_MAX;
      if (v < S_MIN) return S_MIN;
      return v;
    endfunction

    // Round half up, drop the 16 fraction bits, then saturate.
    function longint scale_q16(longint v);
      return clip((v + 32768) >>> 16);
    endfunction

    function void set_reg(int idx, bit [31:0] v);
      case (idx)
        REG_DELAY: cfg.delay_length  = v[DLY_W-1:0];
        REG_GAIN:  cfg.feedback_gain = v[GAIN_W-1:0];
        REG_WET:   cfg.wet_mix       = v[WET_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] reg_value(int idx);
      case (idx)
        REG_DELAY: return 32'(cfg.delay_length);
        REG_GAIN:  return 32'(cfg.feedback_gain);
        REG_WET:   return 32'(cfg.wet_mix);
        default:   return '0;
      endcase
    endfunction

    function int pending();
      return pending_out.size();
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endfunction

    // One input sample transfer: update the echo line and queue the output.
    function void push_sample(bit [SW-1:0] raw);
      longint      x, tap, fb, mix, wet_q;
      int unsigned dly, wet, rd;
      x   = longint'($signed(raw));
      dly = cfg.delay_length;
      wet = cfg.wet_mix;
      // A zero delay acts as one; an over-long delay as the memory depth less one.
      if (dly < 1) dly = 1;
      if (dly >= DEPTH) dly = DEPTH - 1;
      // Wet shares above one act as fully wet.
      if (wet > 32'(Q_ONE)) wet = Q_ONE;
      wet_q = wet;
      rd  = (int'(head) + DEPTH - dly) % DEPTH;
      tap = longint'(echo_line[rd]);
      lowpass = SW'(scale_q16(longint'(lowpass) * longint'(COEF_OLD)
                              + tap * longint'(COEF_NEW)));
      fb = scale_q16(longint'(lowpass) * longint'(cfg.feedback_gain));
      echo_line[head] = SW'(clip(x + fb));
      mix = scale_q16(x * (longint'(Q_ONE) - wet_q) + tap * wet_q);
      pending_out.push_back(mix[SW-1:0]);
      head = DLY_W'((int'(head) + 1) % DEPTH);
    endfunction

    // One output sample transfer: compare with the oldest prediction.
    function void check_sample(bit [SW-1:0] got);
      bit [SW-1:0] want;
      if (pending_out.size() == 0) begin
        report("output with no sample pending", 0, $signed(got));
        return;
      end
      want = pending_out.pop_front();
      if (want != got) report("mix_out", $signed(want), $signed(got));
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [SW-1:0]       in_sample_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [SW-1:0]       mix_out_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [APB_AW-1:0]   paddr        = '0;
  logic [APB_DW-1:0]   pwdata       = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  reverb_predictor sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  damped_feedback_comb_reverb dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mix_out_o    (mix_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 50 MHz clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.push_sample(in_sample_i);
      if (out_valid_o && out_ready_i) sb.check_sample(mix_out_o);
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one sample, with random idle cycles first, and wait for its transfer.
  task automatic send_sample(input logic [SW-1:0] s);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted sample has come out.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(idx * REG_STRIDE);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register, then read it back where the map has one.
  task automatic write_reg(input int idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    sb.set_reg(idx, value);
    if (idx != REG_SPARE) begin
      apb_access(1'b0, idx, '0, rd);
      if (rd !== sb.reg_value(idx)) sb.report("register readback", sb.reg_value(idx), rd);
    end
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SW'($urandom_range(64) - 32);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'd65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_wet();
    case ($urandom_range(4))
      0:       return 32'd0;
      1:       return 32'(Q_ONE);
      2:       return $urandom_range(131071, 65537);
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values with an empty echo line.
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'd1000);
    send_sample(16'hFFFF);
    drain_outputs();

    // Zero delay, full gain and fully wet: feedback saturates quickly.
    write_reg(REG_DELAY, 32'd0);
    write_reg(REG_GAIN, 32'd65535);
    write_reg(REG_WET, 32'(Q_ONE));
    repeat (5) send_sample(16'h7FFF);
    repeat (3) send_sample(16'h8000);
    drain_outputs();

    // Wet share above one, no feedback, and a write outside the map.
    write_reg(REG_DELAY, 32'd2);
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_WET, 32'd131071);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'd12345);
    drain_outputs();

    // Longest delay and fully dry output.
    write_reg(REG_DELAY, 32'd131071);
    write_reg(REG_GAIN, 32'd32768);
    write_reg(REG_WET, 32'd0);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain_outputs();

    // Random phases, each with its own settings and idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (p == 3)
        write_reg(REG_DELAY, 32'd131071);
      else if ($urandom_range(3) == 0)
        write_reg(REG_DELAY, $urandom_range(400, 100));
      else
        write_reg(REG_DELAY, $urandom_range(40));
      write_reg(REG_GAIN, pick_gain());
      write_reg(REG_WET, pick_wet());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold off mid-phase once until the pipeline is empty.
        if (p == 1 && i == PHASE_ITEMS / 2) drain_outputs();
        send_sample(pick_sample());
      end
      drain_outputs();
    end

    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
